@@ src/xml_character_escaper_core_defines.svh @@
// assertion macros shared by the checker files
`ifndef XML_CHARACTER_ESCAPER_CORE_DEFINES_SVH
`define XML_CHARACTER_ESCAPER_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define XCE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xce check failed");

// next-cycle implication, off while reset is high
`define XCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xce check failed");

`endif

@@ src/xce_pkg.sv @@
package xce_pkg;

   localparam int CODE_W      = 16;
   localparam int CHAR_W      = 7;
   localparam int POS_W       = 3;
   // must be a power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // ascii codes
   localparam logic [CHAR_W-1:0] CHR_AMP   = 7'h26;
   localparam logic [CHAR_W-1:0] CHR_HASH  = 7'h23;
   localparam logic [CHAR_W-1:0] CHR_SEMI  = 7'h3b;
   localparam logic [CHAR_W-1:0] CHR_LT    = 7'h3c;
   localparam logic [CHAR_W-1:0] CHR_GT    = 7'h3e;
   localparam logic [CHAR_W-1:0] CHR_QUOT  = 7'h22;
   localparam logic [CHAR_W-1:0] CHR_APOS  = 7'h27;
   localparam logic [CHAR_W-1:0] CHR_BIGU  = 7'h55;
   localparam logic [CHAR_W-1:0] CHR_PLUS  = 7'h2b;
   localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHR_LOWA  = 7'h61;
   localparam logic [CHAR_W-1:0] CHR_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CHR_TILDE = 7'h7e;
   localparam logic [CHAR_W-1:0] CHR_DEL   = 7'h7f;
   localparam logic [CHAR_W-1:0] CHR_L     = 7'h6c;
   localparam logic [CHAR_W-1:0] CHR_G     = 7'h67;
   localparam logic [CHAR_W-1:0] CHR_T     = 7'h74;
   localparam logic [CHAR_W-1:0] CHR_A     = 7'h61;
   localparam logic [CHAR_W-1:0] CHR_M     = 7'h6d;
   localparam logic [CHAR_W-1:0] CHR_P     = 7'h70;
   localparam logic [CHAR_W-1:0] CHR_Q     = 7'h71;
   localparam logic [CHAR_W-1:0] CHR_UU    = 7'h75;
   localparam logic [CHAR_W-1:0] CHR_O     = 7'h6f;
   localparam logic [CHAR_W-1:0] CHR_S     = 7'h73;

   // code unit ranges
   localparam logic [CODE_W-1:0] CU_TAB     = 16'h0009;
   localparam logic [CODE_W-1:0] CU_LF      = 16'h000a;
   localparam logic [CODE_W-1:0] CU_CR      = 16'h000d;
   localparam logic [CODE_W-1:0] CU_DEC_HI1 = 16'hd7ff;
   localparam logic [CODE_W-1:0] CU_DEC_LO2 = 16'he000;
   localparam logic [CODE_W-1:0] CU_DEC_HI2 = 16'hfffd;

   typedef enum logic [2:0] {
      KIND_PLAIN,
      KIND_LT,
      KIND_GT,
      KIND_AMP,
      KIND_QUOT,
      KIND_APOS,
      KIND_DEC,
      KIND_HEX
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CODE_W-1:0]   code_unit;
      logic [POS_W-1:0]    last_pos;
      logic [POS_W-1:0]    ndig;
   } item_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = CHR_ZERO + CHAR_W'(nib);
      end else begin
         c = CHR_LOWA + CHAR_W'(nib - 4'd10);
      end
      return c;
   endfunction

   function automatic logic [16:0] pow10(input logic [POS_W-1:0] k);
      logic [16:0] p;
      case (k)
         3'd0:    p = 17'd1;
         3'd1:    p = 17'd10;
         3'd2:    p = 17'd100;
         3'd3:    p = 17'd1000;
         default: p = 17'd10000;
      endcase
      return p;
   endfunction

   // text of the named entities, position 0 is the ampersand
   function automatic logic [CHAR_W-1:0] entity_char(input kind_type k,
                                                     input logic [POS_W-1:0] pos);
      logic [CHAR_W-1:0] c;
      c = CHR_SEMI;
      if (pos == 3'd0) begin
         c = CHR_AMP;
      end else begin
         case (k)
            KIND_LT: begin
               case (pos)
                  3'd1:    c = CHR_L;
                  3'd2:    c = CHR_T;
                  default: c = CHR_SEMI;
               endcase
            end
            KIND_GT: begin
               case (pos)
                  3'd1:    c = CHR_G;
                  3'd2:    c = CHR_T;
                  default: c = CHR_SEMI;
               endcase
            end
            KIND_AMP: begin
               case (pos)
                  3'd1:    c = CHR_A;
                  3'd2:    c = CHR_M;
                  3'd3:    c = CHR_P;
                  default: c = CHR_SEMI;
               endcase
            end
            KIND_QUOT: begin
               case (pos)
                  3'd1:    c = CHR_Q;
                  3'd2:    c = CHR_UU;
                  3'd3:    c = CHR_O;
                  3'd4:    c = CHR_T;
                  default: c = CHR_SEMI;
               endcase
            end
            KIND_APOS: begin
               case (pos)
                  3'd1:    c = CHR_A;
                  3'd2:    c = CHR_P;
                  3'd3:    c = CHR_O;
                  3'd4:    c = CHR_S;
                  default: c = CHR_SEMI;
               endcase
            end
            default: c = CHR_SEMI;
         endcase
      end
      return c;
   endfunction

endpackage

@@ src/xce_req_if.sv @@
interface xce_req_if;
   logic                          valid;
   logic                          ready;
   logic [xce_pkg::CODE_W-1:0]    code_unit;

   modport source (output valid, output code_unit, input ready);
   modport sink   (input valid, input code_unit, output ready);
endinterface

@@ src/xce_rsp_if.sv @@
interface xce_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [xce_pkg::CHAR_W-1:0]    out_char;
   logic                          run_last;

   modport source (output valid, output out_char, output run_last, input ready);
   modport sink   (input valid, input out_char, input run_last, output ready);
endinterface

@@ src/xce_front.sv @@
module xce_front (
   xce_req_if.sink               req_bus,
   output logic                  push_valid,
   output xce_pkg::item_type     push_item,
   input  logic                  push_ready
);

   logic [xce_pkg::CODE_W-1:0] cu;
   logic                       printable;
   logic                       decimal;

   assign cu         = req_bus.code_unit;
   assign push_valid = req_bus.valid;
   assign req_bus.ready = push_ready;

   assign printable = (cu >= 16'd32) && (cu <= 16'd126);
   assign decimal   = (cu == xce_pkg::CU_TAB) || (cu == xce_pkg::CU_LF) ||
                      (cu == xce_pkg::CU_CR) ||
                      ((cu >= 16'd127) && (cu <= xce_pkg::CU_DEC_HI1)) ||
                      ((cu >= xce_pkg::CU_DEC_LO2) && (cu <= xce_pkg::CU_DEC_HI2));

   always_comb begin
      push_item.code_unit = cu;
      push_item.ndig      = 3'd5;
      if (cu < 16'd10) begin
         push_item.ndig = 3'd1;
      end else if (cu < 16'd100) begin
         push_item.ndig = 3'd2;
      end else if (cu < 16'd1000) begin
         push_item.ndig = 3'd3;
      end else if (cu < 16'd10000) begin
         push_item.ndig = 3'd4;
      end
      if (printable) begin
         case (cu[xce_pkg::CHAR_W-1:0])
            xce_pkg::CHR_LT: begin
               push_item.kind     = xce_pkg::KIND_LT;
               push_item.last_pos = 3'd3;
            end
            xce_pkg::CHR_GT: begin
               push_item.kind     = xce_pkg::KIND_GT;
               push_item.last_pos = 3'd3;
            end
            xce_pkg::CHR_AMP: begin
               push_item.kind     = xce_pkg::KIND_AMP;
               push_item.last_pos = 3'd4;
            end
            xce_pkg::CHR_QUOT: begin
               push_item.kind     = xce_pkg::KIND_QUOT;
               push_item.last_pos = 3'd5;
            end
            xce_pkg::CHR_APOS: begin
               push_item.kind     = xce_pkg::KIND_APOS;
               push_item.last_pos = 3'd5;
            end
            default: begin
               push_item.kind     = xce_pkg::KIND_PLAIN;
               push_item.last_pos = 3'd0;
            end
         endcase
      end else if (decimal) begin
         // & # digits ;
         push_item.kind     = xce_pkg::KIND_DEC;
         push_item.last_pos = push_item.ndig + 3'd2;
      end else begin
         push_item.kind     = xce_pkg::KIND_HEX;
         push_item.last_pos = 3'd5;
      end
   end

endmodule

@@ src/xce_queue.sv @@
module xce_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  xce_pkg::item_type     push_item,
   output logic                  push_ready,
   output logic                  pop_valid,
   output xce_pkg::item_type     pop_item,
   input  logic                  pop_ready
);

   xce_pkg::item_type                mem_ff [xce_pkg::QUEUE_DEPTH];
   logic [xce_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [xce_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [xce_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   assign push_ready = (count_ff != xce_pkg::QCNT_W'(xce_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ src/xce_back.sv @@
module xce_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  xce_pkg::item_type     head_item,
   output logic                  head_pop,
   xce_rsp_if.source             rsp_bus
);

   logic [xce_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [xce_pkg::CODE_W-1:0]   rem_ff, rem_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [xce_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                         last_ff, last_in;

   logic                         out_free, fire, is_last;
   logic [xce_pkg::POS_W-1:0]    k;
   logic [16:0]                  pw, thr, sub;
   logic [3:0]                   digit;
   logic [3:0]                   nib;

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_char = char_ff;
   assign rsp_bus.run_last = last_ff;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fire     = head_valid && out_free;
   assign is_last  = (pos_ff == head_item.last_pos);
   assign head_pop = fire && is_last;

   // one decimal digit per beat, most significant first
   always_comb begin
      k     = xce_pkg::POS_W'(head_item.ndig + 3'd1 - pos_ff);
      pw    = xce_pkg::pow10(k);
      digit = 4'd0;
      sub   = 17'd0;
      for (int d = 1; d <= 9; d++) begin
         thr = 17'(pw * 17'(d));
         if ({1'b0, rem_ff} >= thr) begin
            digit = 4'(d);
            sub   = thr;
         end
      end
   end

   always_comb begin
      case (pos_ff)
         3'd2:    nib = head_item.code_unit[15:12];
         3'd3:    nib = head_item.code_unit[11:8];
         3'd4:    nib = head_item.code_unit[7:4];
         default: nib = head_item.code_unit[3:0];
      endcase
   end

   always_comb begin
      case (head_item.kind)
         xce_pkg::KIND_PLAIN: char_in = head_item.code_unit[xce_pkg::CHAR_W-1:0];
         xce_pkg::KIND_DEC: begin
            if (pos_ff == 3'd0) begin
               char_in = xce_pkg::CHR_AMP;
            end else if (pos_ff == 3'd1) begin
               char_in = xce_pkg::CHR_HASH;
            end else if (is_last) begin
               char_in = xce_pkg::CHR_SEMI;
            end else begin
               char_in = xce_pkg::CHR_ZERO + xce_pkg::CHAR_W'(digit);
            end
         end
         xce_pkg::KIND_HEX: begin
            if (pos_ff == 3'd0) begin
               char_in = xce_pkg::CHR_BIGU;
            end else if (pos_ff == 3'd1) begin
               char_in = xce_pkg::CHR_PLUS;
            end else begin
               char_in = xce_pkg::hex_char(nib);
            end
         end
         default: char_in = xce_pkg::entity_char(head_item.kind, pos_ff);
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      rem_in       = rem_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         last_in      = is_last;
         pos_in       = is_last ? '0 : pos_ff + 3'd1;
         if (head_item.kind == xce_pkg::KIND_DEC) begin
            if (pos_ff == 3'd1) begin
               rem_in = head_item.code_unit;
            end else if ((pos_ff >= 3'd2) && !is_last) begin
               rem_in = rem_ff - sub[xce_pkg::CODE_W-1:0];
            end
         end
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      if (fire) begin
         char_ff <= char_in;
      end
      last_ff <= last_in;
   end

endmodule

@@ src/xml_character_escaper_core.sv @@
// xml character escaper: one 16-bit code unit in per req beat, its escaped text out as a
// run of 1 to 8 ascii characters, one per rsp beat, run_last set on the final one.
// printable ascii passes as one beat, < > & " ' become named entities (4 to 6 beats),
// tab, lf, cr, 127..0xd7ff and 0xe000..0xfffd become &#N; (4 to 8 beats) and everything
// else becomes U+ and four lower-case hex digits (6 beats). the result side emits one
// character per clock while rsp is ready, so plain text flows at one item per cycle when
// rsp does not stall; longer runs hold off req while the two-entry queue is full. the
// first character passes through the queue and then the output register.
// no state survives between items and reset needs no clearing pass.
module xml_character_escaper_core (
   input  logic          clock,
   input  logic          reset,
   xce_req_if.sink       req_bus,
   xce_rsp_if.source     rsp_bus
);

   // classified items from the front end into the queue
   logic                 push_valid;
   logic                 push_ready;
   xce_pkg::item_type    push_item;

   // head of the queue into the character sequencer
   logic                 head_valid;
   logic                 head_pop;
   xce_pkg::item_type    head_item;

   // front end: sorts each code unit into plain, entity, decimal or hex form and
   // works out the run length
   xce_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // short queue decoupling classification from character generation
   xce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop_valid  (head_valid),
      .pop_item   (head_item),
      .pop_ready  (head_pop)
   );

   // back end: walks the run one character per beat into the output register
   xce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ src/xce_checker.sv @@
`include "xml_character_escaper_core_defines.svh"

module xce_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [xce_pkg::CHAR_W-1:0]    out_char,
   input logic                          run_last
);

   // a stalled beat keeps its character
   `XCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_char) && $stable(run_last))

   // escaped text is always printable ascii
   `XCE_ASSERT_NOW(a_printable, clock, reset, rsp_valid, (out_char >= xce_pkg::CHR_SPACE) && (out_char <= xce_pkg::CHR_TILDE))

   // <, >, double and single quotes never leave unescaped
   `XCE_ASSERT_NOW(a_no_markup, clock, reset, rsp_valid, (out_char != xce_pkg::CHR_LT) && (out_char != xce_pkg::CHR_GT) && (out_char != xce_pkg::CHR_QUOT) && (out_char != xce_pkg::CHR_APOS))

   // a semicolon only ever closes a run
   `XCE_ASSERT_NOW(a_semi_last, clock, reset, rsp_valid && (out_char == xce_pkg::CHR_SEMI), run_last)

endmodule

bind xml_character_escaper_core xce_checker u_xce_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .out_char  (rsp_bus.out_char),
   .run_last  (rsp_bus.run_last)
);

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

   // idling, pressure and run-length knobs
   localparam int IDLE_PCT     = 27;
   localparam int HOLD_AT      = 80;
   localparam int HOLD_CYCLES  = 60;
   localparam int CALM_FROM    = 150;
   localparam int CALM_TO      = 230;
   localparam int RANDOM_ITEMS = 285;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 20;
   localparam int QUIET_LIMIT  = 2000;
   localparam int REPORT_MAX   = 10;

   // edges of every class of code unit, named entities and decimal lengths
   localparam int DIRECTED_N = 25;
   localparam logic [xce_pkg::CODE_W-1:0] DIRECTED_UNITS [DIRECTED_N] = '{
      16'h0000, xce_pkg::CU_TAB, xce_pkg::CU_LF, xce_pkg::CU_CR, 16'h001f,
      16'h0020, 16'h007e, 16'h003c, 16'h003e, 16'h0026,
      16'h0022, 16'h0027, 16'h0041, 16'h007f, 16'h03e7,
      16'h03e8, 16'h270f, 16'h2710, xce_pkg::CU_DEC_HI1, 16'hd800,
      16'hdfff, xce_pkg::CU_DEC_LO2, xce_pkg::CU_DEC_HI2, 16'hfffe, 16'hffff
   };

   typedef struct packed {
      logic [xce_pkg::CHAR_W-1:0] ch;
      logic                       last;
   } char_beat_type;

   logic clock;
   logic reset;

   xce_req_if req_bus ();
   xce_rsp_if rsp_bus ();

   xml_character_escaper_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // code units waiting to be offered, characters waiting to come out
   logic [xce_pkg::CODE_W-1:0] pending_units [$];
   char_beat_type              escaped_chars [$];

   int  total_units;
   int  units_sent;
   int  hold_left;
   bit  hold_done;
   int  quiet_cycles;
   int  mismatches;
   int  failures;
   logic calm;

   // window in which neither side idles
   assign calm = (units_sent >= CALM_FROM) && (units_sent < CALM_TO);

   always #1 clock = ~clock;

   // escaped text of one code unit, queued a character at a time
   task automatic push_escaped_run(input logic [xce_pkg::CODE_W-1:0] cu);
      logic [xce_pkg::CHAR_W-1:0] run [8];
      logic [xce_pkg::CHAR_W-1:0] digit_chars [5];
      logic [3:0]                 nib;
      string                      entity;
      int                         n;
      int                         nd;
      int                         v;
      n = 0;
      entity = "";
      if (cu >= 16'd32 && cu <= 16'd126) begin
         // printable ascii, markup characters become named entities
         case (cu[xce_pkg::CHAR_W-1:0])
            xce_pkg::CHR_LT:   entity = "&lt;";
            xce_pkg::CHR_GT:   entity = "&gt;";
            xce_pkg::CHR_AMP:  entity = "&amp;";
            xce_pkg::CHR_QUOT: entity = "&quot;";
            xce_pkg::CHR_APOS: entity = "&apos;";
            default:           entity = "";
         endcase
         if (entity.len() == 0) begin
            run[0] = cu[xce_pkg::CHAR_W-1:0];
            n = 1;
         end else begin
            for (int i = 0; i < entity.len(); i++) begin
               run[n] = xce_pkg::CHAR_W'(entity[i]);
               n = n + 1;
            end
         end
      end else if (cu == xce_pkg::CU_TAB || cu == xce_pkg::CU_LF || cu == xce_pkg::CU_CR ||
                   (cu >= 16'd127 && cu <= xce_pkg::CU_DEC_HI1) ||
                   (cu >= xce_pkg::CU_DEC_LO2 && cu <= xce_pkg::CU_DEC_HI2)) begin
         // decimal reference, no leading zeros
         v = int'(cu);
         nd = 0;
         do begin
            digit_chars[nd] = xce_pkg::CHR_ZERO + xce_pkg::CHAR_W'(v % 10);
            nd = nd + 1;
            v = v / 10;
         end while (v != 0);
         run[0] = xce_pkg::CHR_AMP;
         run[1] = xce_pkg::CHR_HASH;
         n = 2;
         while (nd > 0) begin
            nd = nd - 1;
            run[n] = digit_chars[nd];
            n = n + 1;
         end
         run[n] = xce_pkg::CHR_SEMI;
         n = n + 1;
      end else begin
         // controls, surrogates and noncharacters as U+ and four hex digits
         run[0] = xce_pkg::CHR_BIGU;
         run[1] = xce_pkg::CHR_PLUS;
         n = 2;
         for (int k = 3; k >= 0; k--) begin
            nib = cu[k*4 +: 4];
            if (nib < 4'd10) begin
               run[n] = xce_pkg::CHR_ZERO + xce_pkg::CHAR_W'(nib);
            end else begin
               run[n] = xce_pkg::CHR_LOWA + xce_pkg::CHAR_W'(nib - 4'd10);
            end
            n = n + 1;
         end
      end
      for (int i = 0; i < n; i++) begin
         escaped_chars.push_back('{ch: run[i], last: (i == n - 1)});
      end
   endtask

   // driver: offers code units, predicts each accepted beat
   always @(posedge clock) begin : drive_units
      bit offer;
      if (reset) begin
         req_bus.valid     <= 1'b0;
         req_bus.code_unit <= '0;
         units_sent        <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            push_escaped_run(req_bus.code_unit);
            units_sent <= units_sent + 1;
         end
         // slot is free once the current beat is taken or nothing is offered
         if (!req_bus.valid || req_bus.ready) begin
            offer = (pending_units.size() > 0) &&
                    (calm || hold_left > 0 || $urandom_range(99) >= IDLE_PCT);
            if (offer) begin
               req_bus.valid     <= 1'b1;
               req_bus.code_unit <= pending_units.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, one long hold-off, checks every character beat
   always @(posedge clock) begin : watch_chars
      char_beat_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= 0;
         hold_done     <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (escaped_chars.size() == 0) begin
               failures = failures + 1;
               if (mismatches < REPORT_MAX) begin
                  $display("unexpected beat: char %h last %b",
                           rsp_bus.out_char, rsp_bus.run_last);
               end
               mismatches = mismatches + 1;
            end else begin
               want = escaped_chars.pop_front();
               if (rsp_bus.out_char !== want.ch || rsp_bus.run_last !== want.last) begin
                  failures = failures + 1;
                  if (mismatches < REPORT_MAX) begin
                     $display("mismatch: expected char %h last %b, got char %h last %b",
                              want.ch, want.last, rsp_bus.out_char, rsp_bus.run_last);
                  end
                  mismatches = mismatches + 1;
               end
            end
         end
         // long hold-off so the block fills up and stalls its input
         if (!hold_done && units_sent >= HOLD_AT) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // watchdog: too long without any beat on either side
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus and end of run
   initial begin
      int pick;
      logic [xce_pkg::CODE_W-1:0] cu;
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.code_unit = '0;
      rsp_bus.ready     = 1'b0;
      mismatches        = 0;
      failures          = 0;

      for (int i = 0; i < DIRECTED_N; i++) begin
         pending_units.push_back(DIRECTED_UNITS[i]);
      end
      // plain text, markup, controls, surrogates, the top of the range and any code unit
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            cu = xce_pkg::CODE_W'($urandom_range(126, 32));
         end else if (pick < 55) begin
            case ($urandom_range(4))
               0:       cu = xce_pkg::CODE_W'(xce_pkg::CHR_LT);
               1:       cu = xce_pkg::CODE_W'(xce_pkg::CHR_GT);
               2:       cu = xce_pkg::CODE_W'(xce_pkg::CHR_AMP);
               3:       cu = xce_pkg::CODE_W'(xce_pkg::CHR_QUOT);
               default: cu = xce_pkg::CODE_W'(xce_pkg::CHR_APOS);
            endcase
         end else if (pick < 65) begin
            cu = xce_pkg::CODE_W'($urandom_range(31));
         end else if (pick < 75) begin
            cu = xce_pkg::CODE_W'($urandom_range(16'hdfff, 16'hd800));
         end else if (pick < 80) begin
            cu = xce_pkg::CODE_W'($urandom_range(16'hffff, 16'hfff0));
         end else begin
            cu = xce_pkg::CODE_W'($urandom_range(16'hffff, 0));
         end
         pending_units.push_back(cu);
      end
      total_units = pending_units.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // every code unit taken, then every character seen, then a short drain
      while (units_sent < total_units) @(posedge clock);
      while (escaped_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (escaped_chars.size() != 0) begin
         failures = failures + 1;
         $display("%0d characters never arrived", escaped_chars.size());
      end
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
